/* design/bba_pkg.sv */
package bba_pkg;

	// Map geometry
	localparam int MAX_BLOCKS    = 4096;
	localparam int MAP_WORD_BITS = 32;
	localparam int MAP_WORDS     = MAX_BLOCKS / MAP_WORD_BITS;
	localparam int WORD_AW       = $clog2(MAP_WORDS);
	localparam int BIT_W         = $clog2(MAP_WORD_BITS);

	// Field widths
	localparam int IDX_W    = 12;
	localparam int VOL_W    = 13;
	localparam int STATUS_W = 2;

	// Register port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef logic [MAP_WORD_BITS-1:0] word_t;
	typedef logic [STATUS_W-1:0]      status_t;

	localparam status_t ST_DONE    = 2'd0;
	localparam status_t ST_NO_FREE = 2'd1;
	localparam status_t ST_RANGE   = 2'd2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	// Register select is byte address bit 2.
	localparam logic REG_VOLUME = 1'b0;
	localparam logic REG_FIRST  = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [IDX_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] granted_block;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FREE_WR,
		S_HOLD
	} state_t;

endpackage

/* design/bba_ram.sv */
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/block_bitmap_allocator.sv */
// First-fit block allocator over a 4096-entry in-use bitmap held in a 128 x 32 synchronous
// RAM. An allocate transaction (mode 0) returns the lowest free block at or above
// first_data_block and below min(volume_blocks, 4096), marking it used, or status 1 when no
// such block exists. A free transaction (mode 1) clears the named block's bit and answers
// status 0, or answers status 2 and changes nothing when the index lies outside the data
// region. Every transaction produces exactly one response. The map is scanned one word per
// cycle through the RAM's single read port, up to the full 128 words; the response is posted
// from the hold state once the output register is free. A free reads the word, writes it back
// cleared and then posts; a request rejected on its configuration alone goes straight to hold.
// The block takes one request at a time. After reset every block is free at once: a valid
// flop per map word makes an unwritten word read as all zero, so no clearing pass is needed.
// Configuration registers sit at byte address 0 (volume_blocks) and 4 (first_data_block) and
// should only be written while no transaction is in flight.
module block_bitmap_allocator (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       req_valid,
	output logic                       req_ready,
	input  bba_pkg::req_t              req,

	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output bba_pkg::rsp_t              rsp,

	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bba_pkg::ADDR_W-1:0] paddr,
	input  logic [bba_pkg::DATA_W-1:0] pwdata,
	output logic [bba_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	// Configuration registers.
	logic [bba_pkg::VOL_W-1:0] vol_q;
	logic [bba_pkg::IDX_W-1:0] fdb_q;

	// Control state.
	bba_pkg::state_t               state_q, state_d;
	logic [bba_pkg::MAP_WORDS-1:0] valid_q;
	logic                          rsp_valid_q;

	// Scan pipeline: the check stage sees the word read in the previous cycle.
	logic [bba_pkg::WORD_AW-1:0] rd_ptr_q;
	logic [bba_pkg::WORD_AW-1:0] chk_ptr_s1;
	logic                        vld_s1;
	logic [bba_pkg::BIT_W-1:0]   bit_q;

	// Pending and posted responses.
	bba_pkg::rsp_t pend_q, pend_d;
	bba_pkg::rsp_t rsp_q;
	logic          pend_ld;
	logic          out_ld;

	// RAM port.
	logic                        mem_we;
	logic [bba_pkg::WORD_AW-1:0] mem_waddr;
	logic [bba_pkg::WORD_AW-1:0] mem_raddr;
	bba_pkg::word_t              mem_wdata;
	bba_pkg::word_t              mem_rdata;

	// Region bounds derived from the configuration.
	logic [bba_pkg::VOL_W-1:0]   lim;
	logic [bba_pkg::IDX_W-1:0]   last_blk;
	logic [bba_pkg::WORD_AW-1:0] last_word;
	logic [bba_pkg::BIT_W-1:0]   last_bit;
	logic [bba_pkg::WORD_AW-1:0] fdb_word;
	logic [bba_pkg::BIT_W-1:0]   fdb_bit;
	logic                        region_empty;
	logic                        free_bad;
	logic                        accept;
	logic                        cfg_wr;

	// Word check.
	bba_pkg::word_t            word_data;
	bba_pkg::word_t            below_mask;
	bba_pkg::word_t            above_mask;
	bba_pkg::word_t            guard;
	logic                      found;
	logic [bba_pkg::BIT_W-1:0] hit_bit;

	bba_ram #(
		.WIDTH (bba_pkg::MAP_WORD_BITS),
		.DEPTH (bba_pkg::MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// A volume larger than the map is clipped to the map size.
	assign lim = (vol_q > bba_pkg::VOL_W'(bba_pkg::MAX_BLOCKS))
		? bba_pkg::VOL_W'(bba_pkg::MAX_BLOCKS) : vol_q;
	assign last_blk  = bba_pkg::IDX_W'(lim - bba_pkg::VOL_W'(1));
	assign last_word = last_blk[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
	assign last_bit  = last_blk[bba_pkg::BIT_W-1:0];
	assign fdb_word  = fdb_q[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
	assign fdb_bit   = fdb_q[bba_pkg::BIT_W-1:0];

	// An empty data region also covers the zero-block volume.
	assign region_empty = ({1'b0, fdb_q} >= lim);
	assign free_bad     = ({1'b0, req.block_index} >= lim) || (req.block_index < fdb_q);

	assign req_ready = (state_q == bba_pkg::S_IDLE);
	assign accept    = req_valid && req_ready;

	// A word never written since reset reads as all free.
	assign word_data = vld_s1 ? mem_rdata : '0;

	// Blocks outside the data region look used so the search skips them.
	assign below_mask = (chk_ptr_s1 == fdb_word)
		? ((bba_pkg::word_t'(1) << fdb_bit) - bba_pkg::word_t'(1)) : '0;
	assign above_mask = (chk_ptr_s1 == last_word)
		? ~((bba_pkg::word_t'(2) << last_bit) - bba_pkg::word_t'(1)) : '0;
	assign guard = word_data | below_mask | above_mask;
	assign found = ~&guard;

	// Lowest clear bit of the guarded word.
	always_comb begin
		hit_bit = '0;
		for (int i = bba_pkg::MAP_WORD_BITS - 1; i >= 0; i--) begin
			if (!guard[i]) begin
				hit_bit = bba_pkg::BIT_W'(i);
			end
		end
	end

	// Next state, RAM control and response staging.
	always_comb begin
		state_d   = state_q;
		mem_raddr = rd_ptr_q;
		mem_we    = 1'b0;
		mem_waddr = chk_ptr_s1;
		mem_wdata = word_data | (bba_pkg::word_t'(1) << hit_bit);
		pend_ld   = 1'b0;
		pend_d    = '{status: bba_pkg::ST_DONE, granted_block: '0};
		out_ld    = 1'b0;
		case (state_q)
			bba_pkg::S_IDLE: begin
				if (accept) begin
					if (req.mode == bba_pkg::MODE_ALLOC) begin
						if (region_empty) begin
							pend_d.status = bba_pkg::ST_NO_FREE;
							pend_ld       = 1'b1;
							state_d       = bba_pkg::S_HOLD;
						end else begin
							mem_raddr = fdb_word;
							state_d   = bba_pkg::S_SCAN;
						end
					end else begin
						if (free_bad) begin
							pend_d.status = bba_pkg::ST_RANGE;
							pend_ld       = 1'b1;
							state_d       = bba_pkg::S_HOLD;
						end else begin
							mem_raddr = req.block_index[bba_pkg::IDX_W-1:bba_pkg::BIT_W];
							state_d   = bba_pkg::S_FREE_WR;
						end
					end
				end
			end
			bba_pkg::S_SCAN: begin
				if (found) begin
					mem_we               = 1'b1;
					pend_d.granted_block = {chk_ptr_s1, hit_bit};
					pend_ld              = 1'b1;
					state_d              = bba_pkg::S_HOLD;
				end else if (chk_ptr_s1 == last_word) begin
					pend_d.status = bba_pkg::ST_NO_FREE;
					pend_ld       = 1'b1;
					state_d       = bba_pkg::S_HOLD;
				end
			end
			bba_pkg::S_FREE_WR: begin
				mem_we    = 1'b1;
				mem_wdata = word_data & ~(bba_pkg::word_t'(1) << bit_q);
				pend_ld   = 1'b1;
				state_d   = bba_pkg::S_HOLD;
			end
			bba_pkg::S_HOLD: begin
				if (!rsp_valid_q || rsp_ready) begin
					out_ld  = 1'b1;
					state_d = bba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bba_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Word valid flags stand in for clearing the RAM after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (mem_we) begin
			valid_q[mem_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_ld) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Datapath registers. The read pointer runs one word ahead of the check stage; reads past
	// the last word are harmless because the check stops there.
	always_ff @(posedge clk) begin
		chk_ptr_s1 <= mem_raddr;
		vld_s1     <= valid_q[mem_raddr];
		rd_ptr_q   <= mem_raddr + bba_pkg::WORD_AW'(1);
		if (accept) begin
			bit_q <= req.block_index[bba_pkg::BIT_W-1:0];
		end
		if (pend_ld) begin
			pend_q <= pend_d;
		end
		if (out_ld) begin
			rsp_q <= pend_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Configuration port.
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q <= bba_pkg::VOL_W'(bba_pkg::MAX_BLOCKS);
			fdb_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				bba_pkg::REG_VOLUME: begin
					vol_q <= pwdata[bba_pkg::VOL_W-1:0];
				end
				bba_pkg::REG_FIRST: begin
					fdb_q <= pwdata[bba_pkg::IDX_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			bba_pkg::REG_VOLUME: begin
				prdata = bba_pkg::DATA_W'(vol_q);
			end
			default: begin
				prdata = bba_pkg::DATA_W'(fdb_q);
			end
		endcase
	end

	// The scan never checks a word past the end of the volume.
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bba_pkg::S_SCAN) |-> (chk_ptr_s1 <= last_word))
		else $error("scan checked a word beyond the volume");

	// A map word that has been written is never treated as unwritten afterwards.
	a_valid_set: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> valid_q[$past(mem_waddr)])
		else $error("written map word not marked valid");

	// The map is only written while a transaction is being worked on.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> ((state_q == bba_pkg::S_SCAN) || (state_q == bba_pkg::S_FREE_WR)))
		else $error("map write outside an allocate or free");

	// A granted block always lies inside the data region.
	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == bba_pkg::S_SCAN) && found) |->
			(({chk_ptr_s1, hit_bit} >= fdb_q) && ({1'b0, chk_ptr_s1, hit_bit} < lim)))
		else $error("granted block outside the data region");

endmodule

/* dv/block_bitmap_allocator_tb.sv */
module block_bitmap_allocator_tb;

	import bba_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int RESET_CYCLES    = 9;
	// The slowest legal run is roughly 850 transactions of up to a full map scan each,
	// plus handshake stalls, so this limit leaves a wide margin.
	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int RANDOM_PHASES   = 16;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int HOLD_CYCLES     = 300;
	// Covers a full map scan that may still be in flight.
	localparam int SETTLE_CYCLES   = 140;

	// A directed row is either a request or a register write. For a request, sel
	// carries the mode; for a write, it carries the register select.
	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic             sel;
		logic [VOL_W-1:0] value;
		bit               known;
		status_t          status;
		logic [IDX_W-1:0] block;
	} plan_row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	req_t              req       = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	rsp_t              rsp;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Shadow copy of the allocator: one in-use bit per block and both registers
	// at their reset values.
	logic [MAX_BLOCKS-1:0] block_in_use = '0;
	logic [VOL_W-1:0]      volume_cfg   = VOL_W'(4096);
	logic [IDX_W-1:0]      first_cfg    = '0;

	// Responses still owed by the block, oldest first.
	rsp_t             answers[$];
	// Blocks that were granted and not yet handed back; frees are mostly drawn
	// from here so that the random traffic keeps a realistic occupancy.
	logic [IDX_W-1:0] held_blocks[$];
	plan_row_t        plan[$];

	int fail_count    = 0;
	int req_idle_pct  = 0;
	int rsp_stall_pct = 0;
	bit hold_off_rsp  = 1'b0;

	always #CLK_HALF clk = ~clk;

	block_bitmap_allocator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// Applies one request to the shadow bitmap and returns the response the
	// block owes for it. The volume is clipped to the size of the map, and an
	// allocate walks upward from the first data block to the first clear bit.
	function automatic rsp_t bitmap_answer(req_t r);
		int   lim;
		rsp_t a;
		a = '0;
		lim = (volume_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(volume_cfg);
		if (r.mode == MODE_ALLOC) begin
			a.status = ST_NO_FREE;
			for (int b = int'(first_cfg); b < lim; b++) begin
				if (!block_in_use[b]) begin
					block_in_use[b] = 1'b1;
					a.status = ST_DONE;
					a.granted_block = IDX_W'(b);
					break;
				end
			end
		end else if (int'(r.block_index) >= lim || r.block_index < first_cfg) begin
			a.status = ST_RANGE;
		end else begin
			// Freeing a block that is already free is legal and leaves it clear.
			block_in_use[r.block_index] = 1'b0;
		end
		return a;
	endfunction

	function automatic void plan_request(logic mode, int index, bit known = 1'b0,
			status_t status = ST_DONE, int block = 0);
		plan.push_back('{ROW_REQ, mode, VOL_W'(index), known, status, IDX_W'(block)});
	endfunction

	function automatic void plan_write(logic sel, int value);
		plan.push_back('{ROW_CFG, sel, VOL_W'(value), 1'b0, ST_DONE, '0});
	endfunction

	// Offers one request transaction and returns at the edge where it is taken.
	// The sender may idle first; valid then stays high with a fixed payload until
	// the handshake completes. The expected response is queued at that edge,
	// either the value typed into the directed table or the shadow's answer.
	task automatic send_request(req_t r, bit known, rsp_t known_rsp);
		rsp_t a;
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		a = bitmap_answer(r);
		if (r.mode == MODE_ALLOC && a.status == ST_DONE)
			held_blocks.push_back(a.granted_block);
		answers.push_back(known ? known_rsp : a);
	endtask

	// Stops offering requests and waits until every owed response has come back,
	// which leaves the block idle.
	task automatic wait_for_answers();
		req_valid <= 1'b0;
		while (answers.size() != 0)
			@(posedge clk);
	endtask

	// One APB write: a setup cycle, an access cycle, then an idle pause so that
	// back-to-back writes never touch the bus signals twice in one time step.
	// Bits above the register width carry noise and must be ignored.
	task automatic write_register(logic sel, logic [VOL_W-1:0] value);
		logic [DATA_W-1:0] w;
		w = $urandom();
		w[VOL_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= w;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_VOLUME)
			volume_cfg = value;
		else
			first_cfg = value[IDX_W-1:0];
		@(posedge clk);
	endtask

	// Response side. Normally ready is drawn at random each cycle; on request it
	// drops for a long stretch so that the block backs up onto its input.
	initial begin : rsp_side
		forever begin
			@(posedge clk);
			if (hold_off_rsp) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_rsp = 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	// Every response transaction is compared with the oldest owed response.
	always @(posedge clk) begin : answer_check
		rsp_t expected_rsp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (answers.size() == 0) begin
				fail_count++;
				$display("%0t: response with nothing outstanding: status %0d block %0d",
					$time, rsp.status, rsp.granted_block);
			end else begin
				expected_rsp = answers.pop_front();
				if (rsp.status !== expected_rsp.status) begin
					fail_count++;
					$display("%0t: status mismatch: expected %0d actual %0d",
						$time, expected_rsp.status, rsp.status);
				end
				if (rsp.granted_block !== expected_rsp.granted_block) begin
					fail_count++;
					$display("%0t: granted_block mismatch: expected %0d actual %0d",
						$time, expected_rsp.granted_block, rsp.granted_block);
				end
			end
		end
	end

	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout with %0d responses outstanding", $time, answers.size());
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		req_t             r;
		rsp_t             kr;
		int               pick;
		int               k;
		int               phase;
		int               n;
		logic [VOL_W-1:0] vol;
		logic [IDX_W-1:0] first;

		// Directed part. Right after reset the map is empty, the volume is the
		// full map and the data region starts at block 0, so the first grants
		// come out in order. The block_index of an allocate is don't-care and
		// carries arbitrary patterns.
		plan_request(MODE_ALLOC, 'hfff, 1'b1, ST_DONE, 0);
		plan_request(MODE_ALLOC, 0, 1'b1, ST_DONE, 1);
		plan_request(MODE_FREE, 0, 1'b1, ST_DONE, 0);
		// Freeing a block that is already free still answers done.
		plan_request(MODE_FREE, 0, 1'b1, ST_DONE, 0);
		plan_request(MODE_ALLOC, 'haaa, 1'b1, ST_DONE, 0);
		plan_request(MODE_ALLOC, 'h555, 1'b1, ST_DONE, 2);
		plan_request(MODE_FREE, 4095, 1'b1, ST_DONE, 0);
		// A volume larger than the map behaves as the full map.
		plan_write(REG_VOLUME, 8191);
		plan_request(MODE_FREE, 4095, 1'b1, ST_DONE, 0);
		// A data region of exactly the top block.
		plan_write(REG_FIRST, 4095);
		plan_request(MODE_ALLOC, 0, 1'b1, ST_DONE, 4095);
		plan_request(MODE_ALLOC, 'hfff, 1'b1, ST_NO_FREE, 0);
		plan_request(MODE_FREE, 4094, 1'b1, ST_RANGE, 0);
		plan_request(MODE_FREE, 4095, 1'b1, ST_DONE, 0);
		// A volume of zero blocks refuses everything.
		plan_write(REG_VOLUME, 0);
		plan_request(MODE_ALLOC, 0, 1'b1, ST_NO_FREE, 0);
		plan_request(MODE_FREE, 4095, 1'b1, ST_RANGE, 0);
		plan_request(MODE_FREE, 0, 1'b1, ST_RANGE, 0);
		plan_write(REG_FIRST, 0);
		plan_request(MODE_ALLOC, 'h7ff, 1'b1, ST_NO_FREE, 0);
		// A tiny volume whose blocks are already taken.
		plan_write(REG_VOLUME, 3);
		plan_request(MODE_ALLOC, 0);
		plan_request(MODE_FREE, 3, 1'b1, ST_RANGE, 0);
		plan_request(MODE_FREE, 1);
		plan_request(MODE_ALLOC, 'h800);
		// An empty data region: the first data block lies beyond the volume.
		plan_write(REG_FIRST, 100);
		plan_write(REG_VOLUME, 50);
		plan_request(MODE_ALLOC, 0, 1'b1, ST_NO_FREE, 0);
		plan_request(MODE_FREE, 60, 1'b1, ST_RANGE, 0);
		plan_request(MODE_FREE, 40, 1'b1, ST_RANGE, 0);
		plan_write(REG_VOLUME, 4096);
		plan_write(REG_FIRST, 0);
		plan_request(MODE_ALLOC, 'h123);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers are only written once the block has answered everything.
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				wait_for_answers();
				write_register(plan[i].sel, plan[i].value);
			end else begin
				r.mode = plan[i].sel;
				r.block_index = plan[i].value[IDX_W-1:0];
				kr.status = plan[i].status;
				kr.granted_block = plan[i].block;
				send_request(r, plan[i].known, kr);
			end
		end

		// Random part. Each phase picks a new volume layout and a new idling
		// pattern. Most traffic is allocates and frees of blocks that are
		// actually held; the rest are frees of arbitrary indices, which hit
		// both free blocks and out-of-range indices.
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_for_answers();
			case ($urandom_range(5))
				0: begin
					vol = VOL_W'(4096);
					first = '0;
				end
				1: begin
					vol = VOL_W'($urandom_range(8191));
					first = IDX_W'($urandom_range(4095));
				end
				2: begin
					// Narrow region that fills up quickly and runs out.
					first = IDX_W'($urandom_range(4095));
					vol = VOL_W'(int'(first) + $urandom_range(1, 48));
				end
				3: begin
					first = '0;
					vol = VOL_W'($urandom_range(1, 200));
				end
				4: begin
					case ($urandom_range(3))
						0: vol = '0;
						1: vol = VOL_W'(8191);
						2: vol = VOL_W'(4096);
						default: vol = VOL_W'(1);
					endcase
					first = $urandom_range(1) ? IDX_W'(4095) : '0;
				end
				default: begin
					vol = VOL_W'($urandom_range(4096, 8191));
					first = IDX_W'($urandom_range(4095));
				end
			endcase
			write_register(REG_VOLUME, vol);
			write_register(REG_FIRST, VOL_W'(first));

			case (phase % 4)
				0: begin
					req_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					req_idle_pct = 62;
					rsp_stall_pct = 0;
				end
				2: begin
					req_idle_pct = 0;
					rsp_stall_pct = 62;
				end
				default: begin
					req_idle_pct = 28;
					rsp_stall_pct = 28;
				end
			endcase

			// With the sender running flat out, a long receiver hold-off backs
			// the block up and forces req_ready low.
			if (phase % 8 == 4)
				hold_off_rsp = 1'b1;

			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Now and then the sender goes quiet until the block has drained.
				if (n == ITEMS_PER_PHASE / 2 && phase % 5 == 2)
					wait_for_answers();
				pick = $urandom_range(99);
				if (pick < 55) begin
					r.mode = MODE_ALLOC;
					r.block_index = IDX_W'($urandom());
				end else if (pick < 85 && held_blocks.size() != 0) begin
					k = $urandom_range(held_blocks.size() - 1);
					r.mode = MODE_FREE;
					r.block_index = held_blocks[k];
					held_blocks.delete(k);
				end else begin
					r.mode = MODE_FREE;
					r.block_index = IDX_W'($urandom());
				end
				send_request(r, 1'b0, kr);
			end
		end

		wait_for_answers();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (answers.size() != 0) begin
			fail_count++;
			$display("%0t: %0d responses never arrived", $time, answers.size());
		end
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
